@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

@@ hdl/aes_cbc_pkg.sv @@
// Package with the AES constants, the S-box and the register indexes.
package aes_cbc_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
    localparam int HALF_BITS   = 64;
    localparam int NUM_ROUNDS  = 10;
    localparam int CFG_IDX_W   = 3;

    typedef logic [BLOCK_BITS-1:0] t_block;
    typedef logic [HALF_BITS-1:0]  t_half;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH = 3'd0,
        CFG_KEY_LOW  = 3'd1,
        CFG_IV_HIGH  = 3'd2,
        CFG_IV_LOW   = 3'd3
    } t_cfg_idx;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] sub_byte(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

@@ hdl/aes_cbc_if.sv @@
// Stream interfaces for the plaintext and ciphertext channels.
interface aes_cbc_plain_if;
    logic                   valid;
    logic                   ready;
    aes_cbc_pkg::t_half     plain_high;
    aes_cbc_pkg::t_half     plain_low;
    logic                   message_start;

    modport source (output valid, plain_high, plain_low, message_start, input ready);
    modport sink   (input valid, plain_high, plain_low, message_start, output ready);
endinterface

interface aes_cbc_cipher_if;
    logic                   valid;
    logic                   ready;
    aes_cbc_pkg::t_half     cipher_high;
    aes_cbc_pkg::t_half     cipher_low;

    modport source (output valid, cipher_high, cipher_low, input ready);
    modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

@@ hdl/aes_cbc_keyexp.sv @@
// AES-128 key schedule: all eleven round keys from the configured key.
module aes_cbc_keyexp (
    input  aes_cbc_pkg::t_block i_key,
    output aes_cbc_pkg::t_block o_round_key [aes_cbc_pkg::NUM_ROUNDS+1]
);

    localparam int NUM_WORDS = 4 * (aes_cbc_pkg::NUM_ROUNDS + 1);

    logic [31:0] w_word [NUM_WORDS];

    assign w_word[0] = i_key[127:96];
    assign w_word[1] = i_key[95:64];
    assign w_word[2] = i_key[63:32];
    assign w_word[3] = i_key[31:0];

    for (genvar gi = 4; gi < NUM_WORDS; gi++) begin : g_word
        logic [31:0] w_temp;
        if ((gi % 4) == 0) begin : g_rot
            // Rotate, substitute, and fold in the round constant.
            assign w_temp = {
                aes_cbc_pkg::sub_byte(w_word[gi-1][23:16]) ^ aes_cbc_pkg::RCON[gi/4-1],
                aes_cbc_pkg::sub_byte(w_word[gi-1][15:8]),
                aes_cbc_pkg::sub_byte(w_word[gi-1][7:0]),
                aes_cbc_pkg::sub_byte(w_word[gi-1][31:24])
            };
        end else begin : g_plain
            assign w_temp = w_word[gi-1];
        end
        assign w_word[gi] = w_word[gi-4] ^ w_temp;
    end

    for (genvar gr = 0; gr <= aes_cbc_pkg::NUM_ROUNDS; gr++) begin : g_rk
        assign o_round_key[gr] = {w_word[4*gr], w_word[4*gr+1], w_word[4*gr+2], w_word[4*gr+3]};
    end

endmodule

@@ hdl/aes_cbc_round.sv @@
// One AES encryption round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_cbc_round (
    input  aes_cbc_pkg::t_block i_state,
    input  aes_cbc_pkg::t_block i_round_key,
    input  logic                i_mix_en,
    output aes_cbc_pkg::t_block o_state
);

    logic [7:0] w_in  [16];
    logic [7:0] w_sub [16];
    logic [7:0] w_mix [16];

    for (genvar gb = 0; gb < 16; gb++) begin : g_bytes
        assign w_in[gb] = i_state[127-8*gb -: 8];
    end

    // Row i of column c takes its byte from column c+i.
    for (genvar gc = 0; gc < 4; gc++) begin : g_col
        for (genvar gi = 0; gi < 4; gi++) begin : g_row
            assign w_sub[gc*4+gi] = aes_cbc_pkg::sub_byte(w_in[((gc+gi)%4)*4+gi]);
        end

        logic [7:0] w_all;
        assign w_all = w_sub[gc*4] ^ w_sub[gc*4+1] ^ w_sub[gc*4+2] ^ w_sub[gc*4+3];

        for (genvar gi = 0; gi < 4; gi++) begin : g_mix
            logic [7:0] w_mc;
            assign w_mc = w_sub[gc*4+gi] ^ w_all
                ^ aes_cbc_pkg::xtime(w_sub[gc*4+gi] ^ w_sub[gc*4+((gi+1)%4)]);
            assign w_mix[gc*4+gi] = i_mix_en ? w_mc : w_sub[gc*4+gi];
        end
    end

    for (genvar gb = 0; gb < 16; gb++) begin : g_out
        assign o_state[127-8*gb -: 8] = w_mix[gb] ^ i_round_key[127-8*gb -: 8];
    end

endmodule

@@ hdl/aes128_cbc_encrypt.sv @@
// Top level of the AES-128 CBC encryptor: two register stages around ten unrolled rounds.
// Beats wait in the input register until the result register is free to take them.
// Throughput: one block per cycle unless the receiver stalls; the rounds are unregistered.
// The chaining register is updated as each block enters the result register.
// Reset (synchronous, active low) clears the configuration registers, the chaining value and valid flags.
`include "assert_macros.svh"

module aes128_cbc_encrypt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [aes_cbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  aes_cbc_pkg::t_half          i_cfg_data,
    aes_cbc_plain_if.sink               i_plain,
    aes_cbc_cipher_if.source            o_cipher
);

    // Configuration registers. Change them only while the block is idle; it is not enforced.
    aes_cbc_pkg::t_half r_key_high, r_key_low, r_iv_high, r_iv_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aes_cbc_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_cbc_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                aes_cbc_pkg::CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                aes_cbc_pkg::CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The round keys depend only on the key registers, so the schedule is a
    // static function of configuration and needs no pipelining.
    aes_cbc_pkg::t_block w_round_key [aes_cbc_pkg::NUM_ROUNDS+1];

    aes_cbc_keyexp u_keyexp (
        .i_key       ({r_key_high, r_key_low}),
        .o_round_key (w_round_key)
    );

    // Input stage. It holds one beat until the result register can take it.
    logic                r_in_valid;
    aes_cbc_pkg::t_block r_in_plain;
    logic                r_in_start;
    logic                w_out_free;
    logic                w_advance;

    assign w_out_free    = !o_cipher.valid || o_cipher.ready;
    assign w_advance     = r_in_valid && w_out_free;
    assign i_plain.ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_plain.ready) begin
            r_in_valid <= i_plain.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_plain.valid && i_plain.ready) begin
            r_in_plain <= {i_plain.plain_high, i_plain.plain_low};
            r_in_start <= i_plain.message_start;
        end
    end

    // The chaining value is the ciphertext of the block that advanced last,
    // which is always the one just ahead of the block in the input stage.
    // A message start swaps in the IV instead.
    aes_cbc_pkg::t_block r_chain;
    aes_cbc_pkg::t_block w_chain_sel;
    aes_cbc_pkg::t_block w_state [aes_cbc_pkg::NUM_ROUNDS+1];

    assign w_chain_sel = r_in_start ? {r_iv_high, r_iv_low} : r_chain;
    assign w_state[0]  = r_in_plain ^ w_chain_sel ^ w_round_key[0];

    for (genvar gr = 1; gr <= aes_cbc_pkg::NUM_ROUNDS; gr++) begin : g_round
        aes_cbc_round u_round (
            .i_state     (w_state[gr-1]),
            .i_round_key (w_round_key[gr]),
            .i_mix_en    (1'(gr != aes_cbc_pkg::NUM_ROUNDS)),
            .o_state     (w_state[gr])
        );
    end

    // Result stage and chaining register load together.
    logic                r_out_valid;
    aes_cbc_pkg::t_block r_out_cipher;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_chain <= w_state[aes_cbc_pkg::NUM_ROUNDS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_cipher <= w_state[aes_cbc_pkg::NUM_ROUNDS];
        end
    end

    assign o_cipher.valid       = r_out_valid;
    assign o_cipher.cipher_high = r_out_cipher[127:64];
    assign o_cipher.cipher_low  = r_out_cipher[63:0];

    // A waiting result is always the current chaining value.
    `ASSERT_SAME(a_out_is_chain, i_clk, i_rst_n, r_out_valid, r_out_cipher == r_chain)
    // A beat that cannot move on stays in the input stage.
    `ASSERT_NEXT(a_in_holds, i_clk, i_rst_n, r_in_valid && !w_out_free, r_in_valid)
    // An advancing beat always produces a valid result next cycle.
    `ASSERT_NEXT(a_adv_out, i_clk, i_rst_n, w_advance, r_out_valid)

endmodule

@@ sim/tb_aes128_cbc_encrypt.sv @@
// Self-checking testbench for the AES-128 CBC encryptor.
module tb_aes128_cbc_encrypt;

    // Typed view of one plaintext beat and one ciphertext beat.
    typedef struct packed {
        aes_cbc_pkg::t_half plain_high;
        aes_cbc_pkg::t_half plain_low;
        logic               message_start;
    } t_plain_beat;

    typedef struct packed {
        aes_cbc_pkg::t_half cipher_high;
        aes_cbc_pkg::t_half cipher_low;
    } t_cipher_beat;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [aes_cbc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    aes_cbc_pkg::t_half i_cfg_data = '0;

    aes_cbc_plain_if  plain_ch ();
    aes_cbc_cipher_if cipher_ch ();

    aes128_cbc_encrypt dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_plain    (plain_ch.sink),
        .o_cipher   (cipher_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // The predictor keeps its own copy of the registers and of the chaining value.
    logic [127:0] key_shadow;
    logic [127:0] iv_shadow;
    logic [127:0] chain_value;
    t_cipher_beat cipher_expected [$];

    int error_count = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int cycle_count = 0;
    int starts_sent = 0;
    bit hold_off = 1'b0;
    bit stall_enable = 1'b1;

    // The predictor carries its own copy of the S-box so that it does not lean
    // on the block's package for the cipher arithmetic.
    logic [7:0] sbox_lut [256];
    initial begin
        logic [7:0] tab [256] = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        sbox_lut = tab;
    end

    // Byte n of a 128-bit block, byte 0 being the most significant.
    function automatic logic [7:0] byte_at(logic [127:0] v, int n);
        return v[127 - 8 * n -: 8];
    endfunction

    function automatic logic [7:0] gf_double(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Full AES-128 encryption of one block, with the key schedule worked out inline.
    function automatic logic [127:0] aes128_encrypt(logic [127:0] key, logic [127:0] data);
        logic [7:0]   sched [176];
        logic [7:0]   st [16];
        logic [7:0]   tmp [16];
        logic [7:0]   w [4];
        logic [7:0]   rc;
        logic [7:0]   spare;
        logic [7:0]   mix;
        logic [127:0] result;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) sched[i] = byte_at(key, i);
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) w[j] = sched[(i - 1) * 4 + j];
            if (i % 4 == 0) begin
                spare = w[0];
                w[0] = sbox_lut[w[1]] ^ rc;
                w[1] = sbox_lut[w[2]];
                w[2] = sbox_lut[w[3]];
                w[3] = sbox_lut[spare];
                rc = gf_double(rc);
            end
            for (int j = 0; j < 4; j++) sched[i * 4 + j] = sched[(i - 4) * 4 + j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) st[i] = byte_at(data, i) ^ sched[i];
        for (int r = 1; r <= 10; r++) begin
            // Substitution and row shift: row i of column c comes from column c+i.
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    tmp[c * 4 + i] = sbox_lut[st[((c + i) % 4) * 4 + i]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    mix = tmp[c*4] ^ tmp[c*4+1] ^ tmp[c*4+2] ^ tmp[c*4+3];
                    for (int i = 0; i < 4; i++) w[i] = tmp[c * 4 + i];
                    for (int i = 0; i < 4; i++)
                        tmp[c * 4 + i] = w[i] ^ mix ^ gf_double(w[i] ^ w[(i + 1) % 4]);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ sched[r * 16 + i];
        end
        for (int i = 0; i < 16; i++) result[127 - 8 * i -: 8] = st[i];
        return result;
    endfunction

    // Works out the ciphertext for one accepted beat and advances the chain.
    function automatic void predict_cipher(t_plain_beat beat);
        logic [127:0] ct;
        if (beat.message_start) chain_value = iv_shadow;
        ct = aes128_encrypt(key_shadow, {beat.plain_high, beat.plain_low} ^ chain_value);
        chain_value = ct;
        cipher_expected.push_back(ct);
    endfunction

    task automatic report_mismatch(string what, aes_cbc_pkg::t_half got,
                                   aes_cbc_pkg::t_half want);
        error_count++;
        $display("MISMATCH %s beat %0d: got %h expected %h", what, beats_checked, got, want);
    endtask

    // No gap or a short one most of the time, and now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Cycle counter and overall limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("aes128_cbc_encrypt regression: fail");
            $finish;
        end
    end

    // Receiver side: random stalls, or a fixed long hold-off when asked for.
    initial begin
        int pause;
        cipher_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                cipher_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                cipher_ch.ready <= 1'b1;
                pause = stall_enable ? gap_length() : 0;
                @(posedge i_clk);
                if (pause > 0) begin
                    cipher_ch.ready <= 1'b0;
                    repeat (pause) @(posedge i_clk);
                end
            end
        end
    end

    // Result checker: every accepted ciphertext beat is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_cipher_beat want;
        if (i_rst_n && cipher_ch.valid && cipher_ch.ready) begin
            if (cipher_expected.size() == 0) begin
                error_count++;
                $display("unexpected ciphertext beat %h %h",
                         cipher_ch.cipher_high, cipher_ch.cipher_low);
            end else begin
                want = cipher_expected.pop_front();
                if (cipher_ch.cipher_high !== want.cipher_high)
                    report_mismatch("cipher_high", cipher_ch.cipher_high, want.cipher_high);
                if (cipher_ch.cipher_low !== want.cipher_low)
                    report_mismatch("cipher_low", cipher_ch.cipher_low, want.cipher_low);
            end
            beats_checked++;
        end
    end

    // Offers one plaintext beat, waits for its acceptance and records the prediction.
    // Valid is left high afterward; the next call or the caller drops it.
    task automatic send_plain(aes_cbc_pkg::t_half hi, aes_cbc_pkg::t_half lo, logic start,
                              bit with_gap = 1'b1);
        t_plain_beat beat;
        int pause;
        beat = '{plain_high: hi, plain_low: lo, message_start: start};
        pause = with_gap ? gap_length() : 0;
        if (pause > 0) begin
            plain_ch.valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        plain_ch.valid <= 1'b1;
        plain_ch.plain_high <= hi;
        plain_ch.plain_low <= lo;
        plain_ch.message_start <= start;
        do @(posedge i_clk); while (!plain_ch.ready);
        predict_cipher(beat);
        beats_sent++;
        if (start) starts_sent++;
    endtask

    // Drops valid and waits until the block has handed back every expected beat.
    task automatic drain();
        plain_ch.valid <= 1'b0;
        while (cipher_expected.size() != 0) @(posedge i_clk);
        // The result register sits behind the input register; let the block settle.
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register, only ever called with the block idle.
    task automatic write_reg(aes_cbc_pkg::t_cfg_idx idx, aes_cbc_pkg::t_half value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            aes_cbc_pkg::CFG_KEY_HIGH: key_shadow[127:64] = value;
            aes_cbc_pkg::CFG_KEY_LOW:  key_shadow[63:0]   = value;
            aes_cbc_pkg::CFG_IV_HIGH:  iv_shadow[127:64]  = value;
            aes_cbc_pkg::CFG_IV_LOW:   iv_shadow[63:0]    = value;
            default: ;
        endcase
    endtask

    task automatic load_key_iv(logic [127:0] key, logic [127:0] iv);
        write_reg(aes_cbc_pkg::CFG_KEY_HIGH, key[127:64]);
        write_reg(aes_cbc_pkg::CFG_KEY_LOW, key[63:0]);
        write_reg(aes_cbc_pkg::CFG_IV_HIGH, iv[127:64]);
        write_reg(aes_cbc_pkg::CFG_IV_LOW, iv[63:0]);
    endtask

    function automatic aes_cbc_pkg::t_half rand_half();
        return {$urandom(), $urandom()};
    endfunction

    // Blocks before any start chain from zero under the all-zero reset key.
    task automatic test_chain_before_start();
        send_plain('0, '0, 1'b0);
        send_plain({64{1'b1}}, {64{1'b1}}, 1'b0);
        send_plain(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        drain();
    endtask

    // The FIPS-197 example vector with a zero IV, then field extremes under it and an all-ones key.
    task automatic test_directed_vectors();
        load_key_iv(128'h000102030405060708090a0b0c0d0e0f, '0);
        send_plain(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_plain('0, '0, 1'b0);
        send_plain({64{1'b1}}, '0, 1'b0);
        send_plain('0, {64{1'b1}}, 1'b1);
        drain();
        load_key_iv({128{1'b1}}, {128{1'b1}});
        send_plain({64{1'b1}}, {64{1'b1}}, 1'b1);
        send_plain(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
        send_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
        drain();
    endtask

    // A new key mid-message applies to the next block; a new IV only at the next start.
    task automatic test_midmessage_writes();
        load_key_iv(128'h2b7e151628aed2a6abf7158809cf4f3c,
                    128'h000102030405060708090a0b0c0d0e0f);
        send_plain(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
        send_plain(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
        drain();
        write_reg(aes_cbc_pkg::CFG_IV_HIGH, 64'h1111111111111111);
        write_reg(aes_cbc_pkg::CFG_IV_LOW, 64'h2222222222222222);
        send_plain(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 1'b0);
        drain();
        write_reg(aes_cbc_pkg::CFG_KEY_LOW, 64'hdeadbeefcafef00d);
        send_plain(64'hf69f2445df4f9b17, 64'had2b417be66c3710, 1'b0);
        send_plain(rand_half(), rand_half(), 1'b1);
        drain();
    endtask

    // Writes to indexes above the register file must leave every register unchanged.
    task automatic test_unknown_index();
        for (int idx = 4; idx < 8; idx++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[aes_cbc_pkg::CFG_IDX_W-1:0];
            i_cfg_data <= rand_half();
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        send_plain(rand_half(), rand_half(), 1'b1);
        send_plain(rand_half(), rand_half(), 1'b0);
        drain();
    endtask

    // Random messages of random length under several keys and IVs.
    task automatic test_random_messages(int total);
        int sent;
        int msg_len;
        sent = 0;
        while (sent < total) begin
            case ($urandom_range(0, 3))
                0: load_key_iv('0, {128{1'b1}});
                1: load_key_iv({128{1'b1}}, '0);
                default: load_key_iv({rand_half(), rand_half()}, {rand_half(), rand_half()});
            endcase
            for (int m = 0; m < 6 && sent < total; m++) begin
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
                for (int b = 0; b < msg_len && sent < total; b++) begin
                    // Now and then a stray start lands inside a message.
                    send_plain(rand_half(), rand_half(),
                               (b == 0) || ($urandom_range(0, 19) == 0));
                    sent++;
                end
            end
            drain();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // back-to-back beats, so the block fills up and stalls its input.
    task automatic test_receiver_holdoff();
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int b = 0; b < 24; b++)
                    send_plain(rand_half(), rand_half(), b == 0, 1'b0);
            end
        join
        // A stretch with no idling on either side.
        stall_enable = 1'b0;
        for (int b = 0; b < 40; b++)
            send_plain(rand_half(), rand_half(), b % 10 == 0, 1'b0);
        drain();
        stall_enable = 1'b1;
    endtask

    initial begin
        key_shadow = '0;
        iv_shadow = '0;
        chain_value = '0;
        plain_ch.valid <= 1'b0;
        plain_ch.plain_high <= '0;
        plain_ch.plain_low <= '0;
        plain_ch.message_start <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_chain_before_start();
        test_directed_vectors();
        test_midmessage_writes();
        test_unknown_index();
        test_receiver_holdoff();
        test_random_messages(800);

        drain();
        $display("covered %0d plaintext beats, %0d message starts, %0d ciphertext beats checked",
                 beats_sent, starts_sent, beats_checked);
        $display("with key and IV changes between messages and a long receiver hold-off");
        if (error_count == 0) begin
            $display("aes128_cbc_encrypt regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("aes128_cbc_encrypt regression: fail");
        end
        $finish;
    end
endmodule
